FILE: design/sff_pkg.sv
// Package for the scanline flood fill unit: canvas and stack sizes,
// request/result structs, action codes and controller command/status bundles.
// No dependencies.
`default_nettype none
package sff_pkg;
  localparam int CanvasWidth  = 200;
  localparam int CanvasHeight = 170;
  localparam int StackDepth   = 4096;
  localparam int Pixels       = CanvasWidth * CanvasHeight;
  localparam int AddrW        = $clog2(Pixels);
  localparam int SpW          = $clog2(StackDepth + 1);
  localparam int StkAw        = $clog2(StackDepth);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FLOOD = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] color;
  } request_t;

  typedef struct packed {
    logic [15:0] read_color;
    logic        fill_done;
    logic        seeds_dropped;
  } result_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,      // nothing
    OP_LOAD,      // latch request, start read at request pixel
    OP_WRITE_REQ, // write request pixel if on canvas
    OP_TARGET,    // target = read data, push seed, sp = 1 unless fill color
    OP_POP,       // pop seed, issue read at seed
    OP_LSCAN,     // issue read at xl-1
    OP_LSTEP,     // xl--
    OP_RSTART,    // xr = x, issue read at xr+1
    OP_RSTEP,     // xr++, issue read at xr+1
    OP_PAINT,     // write pixel at i, advance i
    OP_NBEGIN,    // i = xl, choose neighbor row, issue read at i
    OP_NSTEP,     // examine read data, maybe push, advance i, issue read
    OP_NNEXT      // move to row below
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       on_canvas;   // latched request on canvas
    logic       rd_match;    // read data equals target
    logic       tgt_eq_fill; // read data equals fill color
    logic       sp_zero;
    logic       seed_ok;     // popped seed on canvas
    logic       xl_zero;
    logic       xr_last;     // xr+1 beyond width
    logic       paint_last;  // i == xr
    logic       row_valid;   // current neighbor row exists
    logic       nrow_below;  // currently on row below
    logic       i_past;      // i > xr for neighbor scan
  } dp_status_t;
endpackage
`default_nettype wire

FILE: design/sff_datapath.sv
// Datapath of the flood fill unit: canvas memory, seed stack and span registers.
// Depends on sff_pkg.
`default_nettype none
module sff_datapath
  import sff_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire request_t   req,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      sts,
  output logic [15:0]     rd_data,
  output logic            dropped
);
  logic [15:0] canvas [Pixels];
  logic [19:0] stack  [StackDepth];

  request_t    rq;
  logic [15:0] target_color;
  logic [SpW-1:0] sp;
  logic [9:0]  sx, sy, xl, xr, ix, ny;
  logic        below, in_run;
  logic [15:0] q;
  logic [19:0] stk_q;

  // Memory port controls
  logic              m_we;
  logic [AddrW-1:0]  m_waddr, m_raddr;
  logic [15:0]       m_wdata;
  logic              s_we;
  logic [StkAw-1:0]  s_waddr, s_raddr;
  logic [19:0]       s_wdata;

  function automatic logic [AddrW-1:0] addr(input logic [9:0] px, input logic [9:0] py);
    logic [AddrW+10:0] a;
    a = AddrW'(py) * AddrW'(CanvasWidth) + AddrW'(px);
    return a[AddrW-1:0];
  endfunction

  logic [9:0] seed_x, seed_y;
  assign seed_x = stk_q[9:0];
  assign seed_y = stk_q[19:10];

  logic match;
  assign match = (q == target_color);

  // Address and write selection
  always_comb begin
    m_we = 1'b0;
    m_waddr = addr(ix, sy);
    m_wdata = rq.color;
    m_raddr = addr(rq.x, rq.y);
    s_we = 1'b0;
    s_waddr = sp[StkAw-1:0];
    s_wdata = {rq.y, rq.x};
    s_raddr = StkAw'(sp - SpW'(1));
    unique case (cmd.op)
      OP_LOAD:      m_raddr = addr(req.x, req.y);
      OP_WRITE_REQ: begin
        m_we = sts.on_canvas;
        m_waddr = addr(rq.x, rq.y);
      end
      OP_TARGET:    begin
        s_we = 1'b1;
        s_waddr = '0;
      end
      OP_POP:       m_raddr = addr(seed_x, seed_y);
      OP_LSCAN:     m_raddr = addr(xl - 10'd1, sy);
      OP_LSTEP:     m_raddr = addr(xl - 10'd2, sy);
      OP_RSTART:    m_raddr = addr(sx + 10'd1, sy);
      OP_RSTEP:     m_raddr = addr(xr + 10'd2, sy);
      OP_PAINT:     m_we = 1'b1;
      OP_NBEGIN:    m_raddr = addr(xl, below ? sy + 10'd1 : sy - 10'd1);
      OP_NSTEP:     begin
        m_raddr = addr(ix + 10'd1, ny);
        s_we = match && !in_run && (sp < SpW'(StackDepth));
        s_waddr = sp[StkAw-1:0];
        s_wdata = {ny, ix};
      end
      default: ;
    endcase
  end

  // Canvas memory
  always_ff @(posedge clk) begin
    if (m_we) canvas[m_waddr] <= m_wdata;
    q <= canvas[m_raddr];
  end

  // Seed stack memory; read ahead at sp-1
  always_ff @(posedge clk) begin
    if (s_we) stack[s_waddr] <= s_wdata;
    stk_q <= stack[s_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      target_color <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD:   dropped <= 1'b0;
        OP_TARGET: begin
          target_color <= q;
          if (q != rq.color) sp <= SpW'(1);
        end
        OP_POP:    sp <= sp - SpW'(1);
        OP_NSTEP:  if (match && !in_run) begin
          if (sp < SpW'(StackDepth)) sp <= sp + SpW'(1);
          else dropped <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Span registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD:  rq <= req;
      OP_POP:   begin
        sx <= seed_x;
        sy <= seed_y;
        xl <= seed_x;
      end
      OP_LSTEP: xl <= xl - 10'd1;
      OP_RSTART: xr <= sx;
      OP_RSTEP: xr <= xr + 10'd1;
      OP_PAINT: ix <= ix + 10'd1;
      OP_NBEGIN: begin
        ix <= xl;
        ny <= below ? sy + 10'd1 : sy - 10'd1;
        in_run <= 1'b0;
      end
      OP_NSTEP: begin
        in_run <= match;
        ix <= ix + 10'd1;
      end
      default: ;
    endcase
    if (cmd.op == OP_RSTART) ix <= xl;
    if (cmd.op == OP_RSTEP) ix <= xl;
    if (cmd.op == OP_POP) below <= 1'b0;
    if (cmd.op == OP_NNEXT) below <= 1'b1;
  end

  // Status
  always_comb begin
    sts.action      = rq.action;
    sts.on_canvas   = (rq.x < 10'(CanvasWidth)) && (rq.y < 10'(CanvasHeight));
    sts.rd_match    = match;
    sts.tgt_eq_fill = (q == rq.color);
    sts.sp_zero     = (sp == '0);
    sts.seed_ok     = (sx < 10'(CanvasWidth)) && (sy < 10'(CanvasHeight));
    sts.xl_zero     = (xl == '0);
    sts.xr_last     = ({1'b0, xr} + 11'd1 >= 11'(CanvasWidth));
    sts.paint_last  = (ix == xr);
    sts.row_valid   = below ? ({1'b0, sy} + 11'd1 < 11'(CanvasHeight)) : (sy != '0);
    sts.nrow_below  = below;
    sts.i_past      = (ix > xr);
  end

  assign rd_data = q;
endmodule
`default_nettype wire

FILE: design/sff_controller.sv
// Controller state machine of the flood fill unit: sequences requests and
// the span walk. Depends on sff_pkg.
`default_nettype none
module sff_controller
  import sff_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t sts,
  input  wire logic [15:0] rd_data,
  input  wire logic       dropped,
  output logic            busy,
  output dp_cmd_t         cmd,
  output logic            done,
  output result_t         result
);
  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DISP   = 12'b000000000010,
    S_TGT    = 12'b000000000100,
    S_POP    = 12'b000000001000,
    S_SEEDCK = 12'b000000010000,
    S_LCHK   = 12'b000000100000,
    S_RCHK   = 12'b000001000000,
    S_PAINT  = 12'b000010000000,
    S_NROW   = 12'b000100000000,
    S_NCHK   = 12'b001000000000,
    S_PREPOP = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   fill_ok, fill_ok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill_ok <= 1'b0;
    end else begin
      state <= state_next;
      fill_ok <= fill_ok_next;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_next = state;
    fill_ok_next = fill_ok;
    cmd.op = OP_IDLE;
    done = 1'b0;
    result = '0;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.op = OP_LOAD;
        fill_ok_next = 1'b0;
        state_next = S_DISP;
      end
      S_DISP: begin
        // read data for the request pixel is now valid
        done = 1'b1;
        state_next = S_IDLE;
        case (sts.action)
          ACT_WRITE: cmd.op = OP_WRITE_REQ;
          ACT_READ:  if (sts.on_canvas) result.read_color = rd_data;
          ACT_FLOOD: if (sts.on_canvas) begin
            done = 1'b0;
            cmd.op = OP_TARGET;
            state_next = S_TGT;
          end
          default: ;
        endcase
      end
      S_TGT: begin
        // the stack read of entry 0 is issued here
        if (sts.tgt_eq_fill) begin
          done = 1'b1;
          state_next = S_IDLE;
        end else begin
          fill_ok_next = 1'b1;
          state_next = S_POP;
        end
      end
      S_PREPOP: state_next = sts.sp_zero ? S_OUT : S_POP;
      S_POP: begin
        cmd.op = OP_POP;
        state_next = S_SEEDCK;
      end
      S_SEEDCK: begin
        if (!sts.seed_ok || !sts.rd_match) state_next = S_PREPOP;
        else if (sts.xl_zero) begin
          cmd.op = OP_RSTART;
          state_next = S_RCHK;
        end else begin
          cmd.op = OP_LSCAN;
          state_next = S_LCHK;
        end
      end
      // read data holds the pixel left of xl; stop at the canvas edge
      S_LCHK: begin
        if (sts.xl_zero || !sts.rd_match) begin
          cmd.op = OP_RSTART;
          state_next = S_RCHK;
        end else begin
          cmd.op = OP_LSTEP;
          state_next = S_LCHK;
        end
      end
      // read data holds the pixel right of xr; stop at the canvas edge
      S_RCHK: begin
        if (sts.xr_last || !sts.rd_match) state_next = S_PAINT;
        else begin
          cmd.op = OP_RSTEP;
          state_next = S_RCHK;
        end
      end
      S_PAINT: begin
        cmd.op = OP_PAINT;
        if (sts.paint_last) state_next = S_NROW;
      end
      S_NROW: begin
        if (sts.row_valid) begin
          cmd.op = OP_NBEGIN;
          state_next = S_NCHK;
        end else if (sts.nrow_below) state_next = S_PREPOP;
        else begin
          cmd.op = OP_NNEXT;
          state_next = S_NROW;
        end
      end
      S_NCHK: begin
        if (sts.i_past) begin
          if (sts.nrow_below) state_next = S_PREPOP;
          else begin
            cmd.op = OP_NNEXT;
            state_next = S_NROW;
          end
        end else begin
          cmd.op = OP_NSTEP;
          state_next = S_NCHK;
        end
      end
      S_OUT: begin
        done = 1'b1;
        result.fill_done = fill_ok;
        result.seeds_dropped = dropped;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

FILE: design/scanline_flood_fill_unit.sv
// Top level of the scanline flood fill unit: joins controller and datapath.
// Depends on sff_pkg, sff_controller, sff_datapath.
//
//  channel  | handshake      | payload
//  request  | start, busy    | req (request_t)
//  result   | done strobe    | result (result_t)
//
// A write, read, off-canvas fill or unused action strobes done in the cycle
// after acceptance and the unit is then idle, ready for the next request.
// A fill adds a target state, then per popped seed a left edge scan, a
// right edge scan, a paint of the span and one check per pixel of each
// neighbor row; a rejected seed is popped and checked only. A result state
// ends the fill, and the registered canvas read sets the pace. A fill whose
// seed already has the fill color strobes done from the target state.
// Reset is synchronous; the canvas and stack contents are not cleared.
// The receiver cannot stall; done lasts one cycle.
`default_nettype none
module scanline_flood_fill_unit
  import sff_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t req,
  output logic          busy,
  output logic          done,
  output result_t       result
);
  dp_cmd_t     cmd;
  dp_status_t  sts;
  logic [15:0] rd_data;
  logic        dropped;

  sff_datapath u_dp (
    .clk, .rst, .req, .cmd, .sts, .rd_data, .dropped
  );

  sff_controller u_ctl (
    .clk, .rst, .start, .sts, .rd_data, .dropped, .busy, .cmd, .done, .result
  );
endmodule
`default_nettype wire

FILE: tb/sv/tb_scanline_flood_fill_unit.sv
// Self-checking testbench for scanline_flood_fill_unit: pixel writes, reads and
// row-span flood fills checked against a behavioral canvas model kept here.
// Depends on sff_pkg and the scanline_flood_fill_unit RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_scanline_flood_fill_unit;
  import sff_pkg::*;

  localparam int RandomRequests = 440;
  localparam int CycleLimit     = 5000000;
  localparam logic [15:0] WallColor = 16'h7BEF;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t req = '0;
  logic     busy;
  logic     done;
  result_t  result;

  scanline_flood_fill_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // canvas model and fill state
  logic [15:0] canvas [Pixels];
  logic [19:0] seed_lifo [StackDepth];
  int          seed_sp;
  logic [15:0] fill_target;

  // pending requests with their precomputed results; results in flight
  request_t pending_reqs[$];
  result_t  pending_results[$];
  result_t  awaited_results[$];

  int mismatches = 0;
  int results_seen = 0;
  int fills_done = 0;
  int drops_seen = 0;
  int cycles = 0;
  bit calm = 1'b0;

  function automatic bit on_canvas(int px, int py);
    return px < CanvasWidth && py < CanvasHeight;
  endfunction

  function automatic logic [15:0] pixel_at(int px, int py);
    return canvas[py * CanvasWidth + px];
  endfunction

  function automatic bit push_seed(int px, int py);
    if (seed_sp >= StackDepth) return 1'b0;
    seed_lifo[seed_sp] = {py[9:0], px[9:0]};
    seed_sp++;
    return 1'b1;
  endfunction

  // Run a row-span fill on the canvas model; returns {done, dropped}.
  function automatic logic [1:0] run_fill(int sx, int sy, logic [15:0] fcol);
    int px, py, xl, xr, i, ny;
    logic dropped;
    logic [19:0] e;
    dropped = 1'b0;
    if (!on_canvas(sx, sy)) return 2'b00;
    fill_target = pixel_at(sx, sy);
    if (fill_target == fcol) return 2'b00;
    seed_sp = 0;
    void'(push_seed(sx, sy));
    while (seed_sp > 0) begin
      seed_sp--;
      e = seed_lifo[seed_sp];
      px = e[9:0];
      py = e[19:10];
      if (!on_canvas(px, py) || pixel_at(px, py) != fill_target) continue;
      xl = px;
      while (xl > 0 && pixel_at(xl - 1, py) == fill_target) xl--;
      xr = px;
      while (xr + 1 < CanvasWidth && pixel_at(xr + 1, py) == fill_target) xr++;
      for (i = xl; i <= xr; i++) canvas[py * CanvasWidth + i] = fcol;
      for (int n = 0; n < 2; n++) begin
        if (n == 0) begin
          if (py == 0) continue;
          ny = py - 1;
        end else begin
          ny = py + 1;
          if (ny >= CanvasHeight) continue;
        end
        i = xl;
        while (i <= xr) begin
          if (pixel_at(i, ny) == fill_target) begin
            if (!push_seed(i, ny)) dropped = 1'b1;
            while (i <= xr && pixel_at(i, ny) == fill_target) i++;
          end else begin
            i++;
          end
        end
      end
    end
    return {1'b1, dropped};
  endfunction

  // Apply one request to the model and return the result it produces.
  function automatic result_t canvas_result(request_t r);
    result_t res;
    logic [1:0] fr;
    res = '0;
    case (action_t'(r.action))
      ACT_WRITE: if (on_canvas(r.x, r.y)) canvas[r.y * CanvasWidth + r.x] = r.color;
      ACT_READ:  if (on_canvas(r.x, r.y)) res.read_color = pixel_at(r.x, r.y);
      ACT_FLOOD: begin
        fr = run_fill(r.x, r.y, r.color);
        res.fill_done = fr[1];
        res.seeds_dropped = fr[0];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_request(action_t a, int px, int py, logic [15:0] c);
    request_t r;
    r.action = a;
    r.x = px[9:0];
    r.y = py[9:0];
    r.color = c;
    pending_reqs.push_back(r);
    pending_results.push_back(canvas_result(r));
  endtask

  function automatic logic [15:0] pick_color();
    logic [15:0] pal [6] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hA5A5};
    return pal[$urandom_range(5)];
  endfunction

  // Pick one of the two rows at the top or the two rows at the bottom.
  function automatic int band_row();
    int k;
    k = $urandom_range(3);
    return k < 2 ? k : CanvasHeight - 4 + k;
  endfunction

  function automatic int gap_length();
    int k;
    if (calm) return 0;
    k = $urandom_range(99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Drive requests: hold start until accepted, then idle or present the next.
  int gap = 0;
  int sent = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back(pending_results.pop_front());
        sent++;
        if (sent % 150 == 0) calm = ~calm;
        gap = gap_length();
      end
      if ((!start || !busy) && gap == 0 && pending_reqs.size() > 0) begin
        start <= 1'b1;
        req <= pending_reqs.pop_front();
      end else if (!start || !busy) begin
        start <= 1'b0;
        if (gap > 0) gap--;
      end
    end
  end

  // Check each result strobe against the oldest outstanding expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = awaited_results.pop_front();
        if (want.fill_done) fills_done++;
        if (want.seeds_dropped) drops_seen++;
        if (result.read_color !== want.read_color || result.fill_done !== want.fill_done
            || result.seeds_dropped !== want.seeds_dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: read_color %h/%h fill_done %b/%b dropped %b/%b",
                     results_seen, want.read_color, result.read_color, want.fill_done,
                     result.fill_done, want.seeds_dropped, result.seeds_dropped);
        end
      end
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int k, px, py;
    action_t a;
    logic [15:0] c;
    // paint two rows at the top and two at the bottom, each closed off by a
    // wall row whose color no request uses, so nothing reaches unwritten pixels
    for (py = 0; py < CanvasHeight; py++) begin
      if (py > 2 && py < CanvasHeight - 3) continue;
      for (px = 0; px < CanvasWidth; px++)
        queue_request(ACT_WRITE, px, py,
                      (py == 2 || py == CanvasHeight - 3) ? WallColor : pick_color());
    end
    // directed corners, off-canvas cases, unused action and same-color fill
    queue_request(ACT_WRITE, 0, 0, 16'hFFFF);
    queue_request(ACT_WRITE, CanvasWidth - 1, CanvasHeight - 1, 16'h0000);
    queue_request(ACT_READ, 0, 0, 16'h0000);
    queue_request(ACT_READ, CanvasWidth - 1, CanvasHeight - 1, 16'hFFFF);
    queue_request(ACT_WRITE, CanvasWidth, 0, 16'h1234);
    queue_request(ACT_WRITE, 1023, 1023, 16'hFFFF);
    queue_request(ACT_READ, 0, CanvasHeight, 16'h0000);
    queue_request(ACT_READ, 1023, 1023, 16'h0000);
    queue_request(ACT_FLOOD, CanvasWidth, 1, 16'h4321);
    queue_request(ACT_FLOOD, 3, 1023, 16'h4321);
    queue_request(ACT_FLOOD, 10, 1, pixel_at(10, 1));
    queue_request(ACT_NONE, 5, 1, 16'hFFFF);
    queue_request(ACT_FLOOD, 0, 0, 16'h5555);
    queue_request(ACT_READ, 0, 0, 16'h0000);
    queue_request(ACT_FLOOD, CanvasWidth - 1, CanvasHeight - 1, 16'hFFFF);
    queue_request(ACT_READ, CanvasWidth - 1, CanvasHeight - 1, 16'h0000);
    // random mix, mostly inside the painted rows with palette colors
    repeat (RandomRequests) begin
      k = $urandom_range(99);
      a = k < 35 ? ACT_WRITE : k < 70 ? ACT_READ : k < 95 ? ACT_FLOOD : ACT_NONE;
      if ($urandom_range(9) == 0) begin
        px = $urandom_range(1023);
        py = $urandom_range(1023, CanvasHeight);
      end else begin
        px = $urandom_range(CanvasWidth - 1);
        py = band_row();
      end
      c = $urandom_range(3) == 0 ? 16'($urandom) : pick_color();
      if (c == WallColor) c = ~c;
      queue_request(a, px, py, c);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !start && awaited_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("%0d results checked, %0d fills carried out, %0d with dropped seeds",
             results_seen, fills_done, drops_seen);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
